// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the splitter top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pdis_pkg.sv =====
// ----------------------------------------------------------------------------
// pdis_pkg
// Widths, limits and sequencer states of the pulse duration item splitter.
// ----------------------------------------------------------------------------
package pdis_pkg;

  localparam int unsigned TICK_BITS         = 20;
  localparam int unsigned DUR_BITS          = 15;
  localparam int unsigned MAX_HALF_DURATION = 32767;

  localparam logic [TICK_BITS-1:0] MAX_TICKS  = TICK_BITS'(MAX_HALF_DURATION);
  localparam logic [TICK_BITS-1:0] FULL_TICKS = TICK_BITS'(2 * MAX_HALF_DURATION);
  localparam logic [DUR_BITS-1:0]  MAX_DUR    = DUR_BITS'(MAX_HALF_DURATION);

  localparam logic LEVEL_HIGH = 1'b1;
  localparam logic LEVEL_LOW  = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HIGH = 3'b010,
    ST_LOW  = 3'b100
  } pdis_state_t;

endpackage

// ===== rtl/core/pulse_duration_item_splitter_top.sv =====
// ----------------------------------------------------------------------------
// pulse_duration_item_splitter_top
// An accepted beat loads the tick registers and starts the high run.
// A period gives N items (N <= 33), one item per cycle while out_ready is
// high, from the shared subtract/compare unit; in_ready only while idle.
// Reset: synchronous active-low rst_n returns the sequencer to idle and
// drops out_valid; the tick registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_duration_item_splitter_top
  import pdis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TICK_BITS-1:0] in_high_ticks,
  input  logic [TICK_BITS-1:0] in_low_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUR_BITS-1:0]  out_first_duration,
  output logic                 out_first_level,
  output logic [DUR_BITS-1:0]  out_second_duration,
  output logic                 out_second_level,
  output logic                 out_last_item
);

  pdis_state_t          state_r, state_nxt;
  logic [TICK_BITS-1:0] hi_r, hi_nxt;
  logic [TICK_BITS-1:0] lo_r, lo_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DUR_BITS-1:0]  first_dur_r, first_dur_nxt;
  logic                 first_lvl_r, first_lvl_nxt;
  logic [DUR_BITS-1:0]  second_dur_r, second_dur_nxt;
  logic                 second_lvl_r, second_lvl_nxt;
  logic                 last_r, last_nxt;

  // shared unit: one operand, compares against one and two halves
  logic [TICK_BITS-1:0] work;
  logic                 gt_full, gt_max;
  logic [TICK_BITS-1:0] sub_full, sub_max;
  // low-count padding when the high run ends
  logic                 lo_gt_max;
  logic [TICK_BITS-1:0] lo_rem;
  logic [DUR_BITS-1:0]  pad;
  logic                 step;
  logic                 accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign step     = (state_r != ST_IDLE) && (!out_valid_r || out_ready);

  assign work     = (state_r == ST_HIGH) ? hi_r : lo_r;
  assign gt_full  = work > FULL_TICKS;
  assign gt_max   = work > MAX_TICKS;
  assign sub_full = work - FULL_TICKS;
  assign sub_max  = work - MAX_TICKS;

  assign lo_gt_max = lo_r > MAX_TICKS;
  assign lo_rem    = lo_gt_max ? (lo_r - MAX_TICKS) : '0;
  assign pad       = lo_gt_max ? MAX_DUR : lo_r[DUR_BITS-1:0];

  always_comb begin
    state_nxt      = state_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    out_valid_nxt  = out_valid_r;
    first_dur_nxt  = first_dur_r;
    first_lvl_nxt  = first_lvl_r;
    second_dur_nxt = second_dur_r;
    second_lvl_nxt = second_lvl_r;
    last_nxt       = last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      hi_nxt    = in_high_ticks;
      lo_nxt    = in_low_ticks;
      state_nxt = ST_HIGH;
    end

    if (step) begin
      out_valid_nxt = 1'b1;
      unique case (state_r)
        ST_HIGH: begin
          first_lvl_nxt = LEVEL_HIGH;
          priority if (gt_full) begin
            first_dur_nxt  = MAX_DUR;
            second_dur_nxt = MAX_DUR;
            second_lvl_nxt = LEVEL_HIGH;
            last_nxt       = 1'b0;
            hi_nxt         = sub_full;
          end else if (gt_max) begin
            first_dur_nxt  = MAX_DUR;
            second_dur_nxt = sub_max[DUR_BITS-1:0];
            second_lvl_nxt = LEVEL_HIGH;
            last_nxt       = (lo_r == '0);
            state_nxt      = (lo_r == '0) ? ST_IDLE : ST_LOW;
          end else begin
            // short high run: pad the second half from the low count
            first_dur_nxt  = work[DUR_BITS-1:0];
            second_dur_nxt = pad;
            second_lvl_nxt = LEVEL_LOW;
            last_nxt       = (lo_rem == '0);
            lo_nxt         = lo_rem;
            state_nxt      = (lo_rem == '0) ? ST_IDLE : ST_LOW;
          end
        end
        ST_LOW: begin
          first_lvl_nxt  = LEVEL_LOW;
          second_lvl_nxt = LEVEL_LOW;
          priority if (gt_full) begin
            first_dur_nxt  = MAX_DUR;
            second_dur_nxt = MAX_DUR;
            last_nxt       = (sub_full == '0);
            lo_nxt         = sub_full;
            state_nxt      = (sub_full == '0) ? ST_IDLE : ST_LOW;
          end else if (gt_max) begin
            first_dur_nxt  = MAX_DUR;
            second_dur_nxt = sub_max[DUR_BITS-1:0];
            last_nxt       = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            first_dur_nxt  = work[DUR_BITS-1:0];
            second_dur_nxt = '0;
            last_nxt       = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    first_dur_r  <= first_dur_nxt;
    first_lvl_r  <= first_lvl_nxt;
    second_dur_r <= second_dur_nxt;
    second_lvl_r <= second_lvl_nxt;
    last_r       <= last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_first_duration  = first_dur_r;
  assign out_first_level     = first_lvl_r;
  assign out_second_duration = second_dur_r;
  assign out_second_level    = second_lvl_r;
  assign out_last_item       = last_r;

  `ASSERT_NXT(a_accept_starts_high, clk, rst_n, accept, state_r == ST_HIGH, "accepted beat did not start the high run")
  `ASSERT_IMP(a_low_has_ticks, clk, rst_n, state_r == ST_LOW, lo_r != '0, "low run entered with no ticks left")
  `ASSERT_IMP(a_no_high_after_low, clk, rst_n, out_valid_r && !first_lvl_r, !second_lvl_r, "item goes low then high")

endmodule
